>>> rtl/core/lmj_pkg.sv
// ----------------------------------------------------------------------------
// lmj_pkg: shared types and constants for the LiDAR misalignment Jacobian
// Field widths, fixed-point formats, register indexes and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package lmj_pkg;

    // Port and register widths
    localparam int PT_W       = 40;   // point, centre and result width (mm)
    localparam int DIFF_W     = PT_W + 1;
    localparam int ENT_W      = 16;   // Q1.14 rotation / trig entry
    localparam int ROW_W      = 3 * ENT_W;
    localparam int TRIG_W     = 2 * ENT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;
    localparam int FRAC       = 14;

    // Coefficient datapath widths
    localparam int UV_W    = 33;              // u, v: sum of two Q.28 products
    localparam int CPROD_W = 48;              // u*b_j, v*c_j in Q.42
    localparam int CSUM_W  = 50;              // u*b_j + v*c_j plus rounding
    localparam int KR_W    = CSUM_W - 2 * FRAC; // roll coefficient, Q.14
    localparam int KYP_W   = 2 * ENT_W;       // a_i*b_j in Q.28
    localparam int KY_W    = KYP_W - FRAC;    // yaw coefficient, Q.14

    // Point datapath widths: d split into a signed high and unsigned low part
    localparam int DLO_W  = 24;
    localparam int DHI_W  = DIFF_W - DLO_W;
    localparam int PHI_W  = KR_W + DHI_W;
    localparam int PLO_W  = KR_W + DLO_W + 1;
    localparam int TERM_W = 64;
    localparam int SUM_W  = TERM_W + 2;
    localparam int RND_W  = SUM_W - FRAC;

    // Cycles from an accepted start to the done strobe being sampled
    localparam int LATENCY = 8;

    // Rounding offsets (half an LSB of the target format)
    localparam logic signed [CSUM_W-1:0] CSUM_HALF = CSUM_W'(1) <<< (2 * FRAC - 1);
    localparam logic signed [KYP_W-1:0]  KY_HALF   = KYP_W'(1) <<< (FRAC - 1);
    localparam logic signed [SUM_W-1:0]  SUM_HALF  = SUM_W'(1) <<< (FRAC - 1);

    // Result limits
    localparam logic signed [PT_W-1:0] PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
    localparam logic signed [PT_W-1:0] PT_MIN = {1'b1, {(PT_W-1){1'b0}}};

    // Reset value of the roll trig register: sine 0, cosine 1.0
    localparam logic [TRIG_W-1:0] ROLL_TRIG_RST = 32'h4000_0000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_CENTER_Z  = 3'd2,
        REG_ROW_A     = 3'd3,
        REG_ROW_B     = 3'd4,
        REG_ROW_C     = 3'd5,
        REG_ROLL_TRIG = 3'd6
    } cfg_reg_t;

    typedef logic signed [ENT_W-1:0] ent_t;

    // Clamp a rounded sum to the signed result range
    function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [RND_W-1:0] v);
        logic signed [PT_W-1:0] r;
        if (v[RND_W-1:PT_W-1] == {(RND_W-PT_W+1){1'b0}} ||
            v[RND_W-1:PT_W-1] == {(RND_W-PT_W+1){1'b1}})
        begin
            r = v[PT_W-1:0];
        end
        else if (v[RND_W-1])
        begin
            r = PT_MIN;
        end
        else
        begin
            r = PT_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lidar_misalign_jacobian.sv
// ----------------------------------------------------------------------------
// lidar_misalign_jacobian: roll/yaw partial derivatives for strip adjustment
// Eight-stage pipeline, one point per clock, six saturated 40-bit results.
// ----------------------------------------------------------------------------
// Usage:
//   Points are accepted on a rising edge where start is high and busy is low.
//   busy never rises, so a point may be presented on every clock.
//   Each point yields one result set, shown for exactly one cycle with done
//   high; the transfer completes at the edge that ends that cycle. The
//   receiver cannot stall, so nothing is ever held back.
//   Throughput is one point per cycle, set by the fully pipelined
//   multiplier array (36 point products per cycle).
//   The rotation coefficients are formed by a free-running three-stage
//   pipeline from the configuration registers; configuration is written on
//   the cfg_valid/cfg_ready channel (cfg_ready is always high) and takes
//   effect for the next accepted point. The user must write only while no
//   point is in flight; the block does not enforce this. Reset clears the in-flight
//   valid bits and loads the register defaults (centres and rows 0, sine 0, cosine 1.0).
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_misalign_jacobian (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lmj_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lmj_pkg::CFG_DATA_W-1:0]      cfg_data,
    // point command
    input  logic                                start,
    output logic                                busy,
    input  logic signed [lmj_pkg::PT_W-1:0]     point_x,
    input  logic signed [lmj_pkg::PT_W-1:0]     point_y,
    input  logic signed [lmj_pkg::PT_W-1:0]     point_z,
    input  logic                                in_last,
    // results
    output logic                                done,
    output logic signed [lmj_pkg::PT_W-1:0]     dx_droll,
    output logic signed [lmj_pkg::PT_W-1:0]     dx_dyaw,
    output logic signed [lmj_pkg::PT_W-1:0]     dy_droll,
    output logic signed [lmj_pkg::PT_W-1:0]     dy_dyaw,
    output logic signed [lmj_pkg::PT_W-1:0]     dz_droll,
    output logic signed [lmj_pkg::PT_W-1:0]     dz_dyaw,
    output logic                                out_last
);

    import lmj_pkg::*;

    localparam int NSTG = LATENCY;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [PT_W-1:0]   center_reg [3];
    logic [ROW_W-1:0]         row_a_reg;
    logic [ROW_W-1:0]         row_b_reg;
    logic [ROW_W-1:0]         row_c_reg;
    logic [TRIG_W-1:0]        roll_trig_reg;
    logic                     cfg_wr;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Load the addressed register; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 3; j++)
            begin
                center_reg[j] <= '0;
            end
            row_a_reg     <= '0;
            row_b_reg     <= '0;
            row_c_reg     <= '0;
            roll_trig_reg <= ROLL_TRIG_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:  center_reg[0] <= $signed(cfg_data[PT_W-1:0]);
                REG_CENTER_Y:  center_reg[1] <= $signed(cfg_data[PT_W-1:0]);
                REG_CENTER_Z:  center_reg[2] <= $signed(cfg_data[PT_W-1:0]);
                REG_ROW_A:     row_a_reg     <= cfg_data[ROW_W-1:0];
                REG_ROW_B:     row_b_reg     <= cfg_data[ROW_W-1:0];
                REG_ROW_C:     row_c_reg     <= cfg_data[ROW_W-1:0];
                REG_ROLL_TRIG: roll_trig_reg <= cfg_data[TRIG_W-1:0];
                default:       ;
            endcase
        end
    end

    // Unpack rotation entries and roll sine/cosine
    ent_t ent_a [3];
    ent_t ent_b [3];
    ent_t ent_c [3];
    ent_t sin_r;
    ent_t cos_r;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            ent_a[j] = $signed(row_a_reg[ENT_W*j +: ENT_W]);
            ent_b[j] = $signed(row_b_reg[ENT_W*j +: ENT_W]);
            ent_c[j] = $signed(row_c_reg[ENT_W*j +: ENT_W]);
        end
        sin_r = $signed(roll_trig_reg[ENT_W-1:0]);
        cos_r = $signed(roll_trig_reg[TRIG_W-1:ENT_W]);
    end

    // ------------------------------------------------------------------
    // Coefficient pipeline (free running from the register values)
    // ------------------------------------------------------------------
    logic signed [UV_W-1:0]    u_reg  [3];
    logic signed [UV_W-1:0]    v_reg  [3];
    logic signed [KYP_W-1:0]   ab_reg [3][3];
    logic signed [CPROD_W-1:0] ub_reg [3][3];
    logic signed [CPROD_W-1:0] vc_reg [3][3];
    logic signed [KY_W-1:0]    ky_reg [3][3];
    logic signed [KR_W-1:0]    kr_reg [3][3];
    logic signed [KYP_W-1:0]   ab_rnd [3][3];
    logic signed [CSUM_W-1:0]  csum   [3][3];

    // Round the Q.42 roll and Q.28 yaw coefficients to Q.14, half up
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ab_rnd[i][j] = ab_reg[i][j] + KY_HALF;
                csum[i][j]   = CSUM_W'(ub_reg[i][j]) + CSUM_W'(vc_reg[i][j]) + CSUM_HALF;
            end
        end
    end

    // Stage u, v and a_i*b_j, then u*b_j and v*c_j, then the rounded sums
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_reg[i] <= UV_W'(ent_c[i]) * UV_W'(cos_r) - UV_W'(ent_b[i]) * UV_W'(sin_r);
            v_reg[i] <= -(UV_W'(ent_b[i]) * UV_W'(cos_r)) - UV_W'(ent_c[i]) * UV_W'(sin_r);
            for (int j = 0; j < 3; j++)
            begin
                ab_reg[i][j] <= KYP_W'(ent_a[i]) * KYP_W'(ent_b[j]);
                ub_reg[i][j] <= CPROD_W'(u_reg[i]) * CPROD_W'(ent_b[j]);
                vc_reg[i][j] <= CPROD_W'(v_reg[i]) * CPROD_W'(ent_c[j]);
                ky_reg[i][j] <= ab_rnd[i][j][KYP_W-1:FRAC];
                kr_reg[i][j] <= csum[i][j][CSUM_W-1:2*FRAC];
            end
        end
    end

    // ------------------------------------------------------------------
    // Point pipeline
    // ------------------------------------------------------------------
    logic                      accept;
    logic [NSTG-1:0]           vld_reg;
    logic [NSTG-1:0]           last_reg;
    logic signed [DIFF_W-1:0]  d1_reg [3];
    logic signed [DIFF_W-1:0]  d2_reg [3];
    logic signed [DIFF_W-1:0]  d3_reg [3];
    logic signed [DIFF_W-1:0]  d4_reg [3];
    logic signed [PT_W-1:0]    pt_in  [3];
    logic signed [PHI_W-1:0]   prh_reg [3][3];
    logic signed [PLO_W-1:0]   prl_reg [3][3];
    logic signed [PHI_W-1:0]   pyh_reg [3][3];
    logic signed [PLO_W-1:0]   pyl_reg [3][3];
    logic signed [TERM_W-1:0]  tr_reg  [3][3];
    logic signed [TERM_W-1:0]  ty_reg  [3][3];
    logic signed [SUM_W-1:0]   sr_reg  [3];
    logic signed [SUM_W-1:0]   sy_reg  [3];
    logic signed [PT_W-1:0]    roll_reg [3];
    logic signed [PT_W-1:0]    yaw_reg  [3];
    logic signed [DHI_W-1:0]   d_hi [3];
    logic signed [DLO_W:0]     d_lo [3];

    assign accept = start && !busy;
    assign pt_in[0] = point_x;
    assign pt_in[1] = point_y;
    assign pt_in[2] = point_z;

    // Split the difference into a signed high part and a zero-extended low part
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            d_hi[j] = $signed(d4_reg[j][DIFF_W-1:DLO_W]);
            d_lo[j] = $signed({1'b0, d4_reg[j][DLO_W-1:0]});
        end
    end

    // Advance valid bits; clear them on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NSTG-2:0], accept};
        end
    end

    // Advance the payload through the stages
    always_ff @(posedge clk)
    begin
        last_reg <= {last_reg[NSTG-2:0], in_last};
        for (int j = 0; j < 3; j++)
        begin
            // subtract centre, then delay until the coefficients line up
            d1_reg[j] <= DIFF_W'(pt_in[j]) - DIFF_W'(center_reg[j]);
            d2_reg[j] <= d1_reg[j];
            d3_reg[j] <= d2_reg[j];
            d4_reg[j] <= d3_reg[j];
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                // partial products of coefficient times difference
                prh_reg[i][j] <= PHI_W'(kr_reg[i][j]) * PHI_W'(d_hi[j]);
                prl_reg[i][j] <= PLO_W'(kr_reg[i][j]) * PLO_W'(d_lo[j]);
                pyh_reg[i][j] <= PHI_W'(ky_reg[i][j]) * PHI_W'(d_hi[j]);
                pyl_reg[i][j] <= PLO_W'(ky_reg[i][j]) * PLO_W'(d_lo[j]);
                // recombine into full products
                tr_reg[i][j] <= (TERM_W'(prh_reg[i][j]) <<< DLO_W) + TERM_W'(prl_reg[i][j]);
                ty_reg[i][j] <= (TERM_W'(pyh_reg[i][j]) <<< DLO_W) + TERM_W'(pyl_reg[i][j]);
            end
            // sum over the three axes with the rounding offset
            sr_reg[i] <= SUM_W'(tr_reg[i][0]) + SUM_W'(tr_reg[i][1])
                       + SUM_W'(tr_reg[i][2]) + SUM_HALF;
            sy_reg[i] <= SUM_W'(ty_reg[i][0]) + SUM_W'(ty_reg[i][1])
                       + SUM_W'(ty_reg[i][2]) + SUM_HALF;
            // drop the fraction and clamp
            roll_reg[i] <= sat_pt(sr_reg[i][SUM_W-1:FRAC]);
            yaw_reg[i]  <= sat_pt(sy_reg[i][SUM_W-1:FRAC]);
        end
    end

    // Drive the result ports
    assign done     = vld_reg[NSTG-1];
    assign out_last = last_reg[NSTG-1];
    assign dx_droll = roll_reg[0];
    assign dx_dyaw  = yaw_reg[0];
    assign dy_droll = roll_reg[1];
    assign dy_dyaw  = yaw_reg[1];
    assign dz_droll = roll_reg[2];
    assign dz_dyaw  = yaw_reg[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LATENCY) done)
        else $error("accepted point produced no done strobe");

    a_done_has_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("done strobe without a matching accepted point");

    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LATENCY) (out_last == $past(in_last, LATENCY)))
        else $error("out_last does not match in_last of its point");

    a_trig_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && cfg_index == REG_ROLL_TRIG)
            |=> (roll_trig_reg == $past(cfg_data[TRIG_W-1:0])))
        else $error("roll trig register write lost");

endmodule

`default_nettype wire

>>> tb/lmj_checker.sv
// ----------------------------------------------------------------------------
// lmj_checker: scoreboard for the LiDAR misalignment Jacobian
// Watches the register channel, the point command and the result strobe.
// Keeps a shadow copy of the registers and works out the six roll/yaw
// partials of every accepted point. Each strobed result set is compared
// with the oldest one still waiting.
// ----------------------------------------------------------------------------
module lmj_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [lmj_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lmj_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic signed [lmj_pkg::PT_W-1:0]      point_x,
    input  logic signed [lmj_pkg::PT_W-1:0]      point_y,
    input  logic signed [lmj_pkg::PT_W-1:0]      point_z,
    input  logic                                 in_last,
    input  logic                                 done,
    input  logic signed [lmj_pkg::PT_W-1:0]      dx_droll,
    input  logic signed [lmj_pkg::PT_W-1:0]      dx_dyaw,
    input  logic signed [lmj_pkg::PT_W-1:0]      dy_droll,
    input  logic signed [lmj_pkg::PT_W-1:0]      dy_dyaw,
    input  logic signed [lmj_pkg::PT_W-1:0]      dz_droll,
    input  logic signed [lmj_pkg::PT_W-1:0]      dz_dyaw,
    input  logic                                 out_last,
    output int                                   mismatches,
    output int                                   pending,
    output int                                   checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import lmj_pkg::*;

    // Wide enough for every intermediate product and sum without loss
    typedef logic signed [95:0] acc_t;
    // One result set: six partials, then out_last in slot 6
    typedef logic [6:0][PT_W-1:0] deriv_t;

    localparam acc_t ONE = 1;

    logic [PT_W-1:0]   ctr [3];
    logic [ROW_W-1:0]  rows [3];
    logic [TRIG_W-1:0] roll_sc;
    deriv_t            deriv_q [$];

    string field_name [7] = '{"dx_droll", "dx_dyaw", "dy_droll", "dy_dyaw",
                              "dz_droll", "dz_dyaw", "out_last"};

    initial
    begin
        mismatches = 0;
        pending    = 0;
        checked    = 0;
    end

    // Round half up: floor(v / 2^sh + 1/2)
    function automatic acc_t rnd_shr(input acc_t v, input int sh);
        return (v + (ONE <<< (sh - 1))) >>> sh;
    endfunction

    // Clamp to the signed 40-bit result range
    function automatic logic [PT_W-1:0] clamp_mm(input acc_t v);
        if (v > PT_MAX)
            return PT_MAX;
        if (v < PT_MIN)
            return PT_MIN;
        return v[PT_W-1:0];
    endfunction

    // Roll and yaw partials of the three observation rows for one point
    function automatic deriv_t predict_partials(input logic signed [PT_W-1:0] px,
                                                input logic signed [PT_W-1:0] py,
                                                input logic signed [PT_W-1:0] pz,
                                                input logic last);
        acc_t   d [3];
        acc_t   a [3];
        acc_t   b [3];
        acc_t   c [3];
        acc_t   s, k, u, v, kr, ky, roll, yaw;
        deriv_t r;
        s = $signed(roll_sc[ENT_W-1:0]);
        k = $signed(roll_sc[TRIG_W-1:ENT_W]);
        d[0] = px - $signed(ctr[0]);
        d[1] = py - $signed(ctr[1]);
        d[2] = pz - $signed(ctr[2]);
        for (int j = 0; j < 3; j++)
        begin
            a[j] = $signed(rows[0][ENT_W*j +: ENT_W]);
            b[j] = $signed(rows[1][ENT_W*j +: ENT_W]);
            c[j] = $signed(rows[2][ENT_W*j +: ENT_W]);
        end
        for (int i = 0; i < 3; i++)
        begin
            u    = -b[i] * s + c[i] * k;
            v    = -b[i] * k - c[i] * s;
            roll = 0;
            yaw  = 0;
            for (int j = 0; j < 3; j++)
            begin
                kr   = rnd_shr(u * b[j] + v * c[j], 2 * FRAC);
                ky   = rnd_shr(a[i] * b[j], FRAC);
                roll = roll + kr * d[j];
                yaw  = yaw + ky * d[j];
            end
            r[2*i]   = clamp_mm(rnd_shr(roll, FRAC));
            r[2*i+1] = clamp_mm(rnd_shr(yaw, FRAC));
        end
        r[6] = {{(PT_W-1){1'b0}}, last};
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deriv_t want;
        deriv_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ctr[i]  = '0;
                rows[i] = '0;
            end
            roll_sc = ROLL_TRIG_RST;
            deriv_q.delete();
            pending = 0;
        end
        else
        begin
            // Compare a strobed result set with the oldest expectation
            if (done)
            begin
                got[0] = dx_droll;
                got[1] = dx_dyaw;
                got[2] = dy_droll;
                got[3] = dy_dyaw;
                got[4] = dz_droll;
                got[5] = dz_dyaw;
                got[6] = {{(PT_W-1){1'b0}}, out_last};
                if (deriv_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result set with no point waiting for it", $realtime);
                end
                else
                begin
                    want = deriv_q.pop_front();
                    checked++;
                    for (int f = 0; f < 7; f++)
                    begin
                        if (got[f] !== want[f])
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("%0t: %s expected %0d got %0d", $realtime,
                                         field_name[f], $signed(want[f]), $signed(got[f]));
                        end
                    end
                end
            end

            // Predict each accepted point with the registers in force
            if (start && !busy)
                deriv_q.push_back(predict_partials(point_x, point_y, point_z, in_last));

            // Track register transfers; unmapped indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_CENTER_X:  ctr[0]  = cfg_data[PT_W-1:0];
                    REG_CENTER_Y:  ctr[1]  = cfg_data[PT_W-1:0];
                    REG_CENTER_Z:  ctr[2]  = cfg_data[PT_W-1:0];
                    REG_ROW_A:     rows[0] = cfg_data[ROW_W-1:0];
                    REG_ROW_B:     rows[1] = cfg_data[ROW_W-1:0];
                    REG_ROW_C:     rows[2] = cfg_data[ROW_W-1:0];
                    REG_ROLL_TRIG: roll_sc = cfg_data[TRIG_W-1:0];
                    default:       ;
                endcase
            end

            pending = deriv_q.size();
        end
    end

endmodule

>>> tb/tb_lidar_misalign_jacobian.sv
// ----------------------------------------------------------------------------
// tb_lidar_misalign_jacobian: regression for the misalignment Jacobian
// Streams points through the block under a series of register settings.
// A short directed part covers reset defaults, range extremes, saturation,
// half-LSB rounding and a write to an unmapped index. Random phases then
// follow, with bursty gaps. The checker beside the block predicts and
// compares every result set.
// ----------------------------------------------------------------------------
module tb_lidar_misalign_jacobian;
    timeunit 1ns;
    timeprecision 1ps;
    import lmj_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int PHASES     = 9;
    localparam int PHASE_PTS  = 205;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;
    logic                    start     = 1'b0;
    logic signed [PT_W-1:0]  point_x   = '0;
    logic signed [PT_W-1:0]  point_y   = '0;
    logic signed [PT_W-1:0]  point_z   = '0;
    logic                    in_last   = 1'b0;
    logic                    cfg_ready;
    logic                    busy;
    logic                    done;
    logic signed [PT_W-1:0]  dx_droll, dx_dyaw, dy_droll, dy_dyaw, dz_droll, dz_dyaw;
    logic                    out_last;
    int                      mismatches;
    int                      pending;
    int                      checked;

    logic signed [PT_W-1:0]  cur_ctr [3];
    int                      gap_pct   = 0;
    int                      pts_sent  = 0;
    int                      settings  = 0;

    lidar_misalign_jacobian u_top (.*);

    lmj_checker u_checker (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // One register transfer, with an optional idle burst ahead of it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Load all seven registers; junk rides above the centre and roll trig widths
    task automatic load_setting(input logic signed [PT_W-1:0] cx, cy, cz,
                                input logic [ROW_W-1:0] ra, rb, rc,
                                input logic [TRIG_W-1:0] rt, input logic stray);
        write_reg(REG_CENTER_X, {8'($urandom), cx});
        write_reg(REG_CENTER_Y, {8'($urandom), cy});
        write_reg(REG_CENTER_Z, {8'($urandom), cz});
        write_reg(REG_ROW_A, ra);
        if (stray)
            write_reg(REG_UNMAPPED, {$urandom, 16'($urandom)});
        write_reg(REG_ROW_B, rb);
        write_reg(REG_ROW_C, rc);
        write_reg(REG_ROLL_TRIG, {16'($urandom), rt});
        cfg_valid <= 1'b0;
        cur_ctr[0] = cx;
        cur_ctr[1] = cy;
        cur_ctr[2] = cz;
        settings++;
    endtask

    // Present one point and hold it until the transfer
    task automatic send_point(input logic signed [PT_W-1:0] x, y, z, input logic last);
        start   <= 1'b1;
        point_x <= x;
        point_y <= y;
        point_z <= z;
        in_last <= last;
        do
            @(posedge clk);
        while (busy);
        pts_sent++;
    endtask

    // Hold off new points until every expected result set has come back
    task automatic settle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    function automatic logic [ENT_W-1:0] rand_entry();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h4000;
            3:       return 16'hC000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [PT_W-1:0] rand_coord(input logic signed [PT_W-1:0] c);
        logic [63:0]       r64;
        logic signed [20:0] jit;
        r64 = {$urandom, $urandom};
        jit = 21'($urandom);
        case ($urandom_range(0, 7))
            0:       return PT_MAX;
            1:       return PT_MIN;
            2:       return '0;
            3, 4:    return c + jit;
            default: return r64[PT_W-1:0];
        endcase
    endfunction

    initial
    begin
        logic [63:0]            r64 [3];
        logic signed [31:0]     near [3];
        logic [ROW_W-1:0]       rw [3];
        logic signed [PT_W-1:0] ext [3];
        int                     pick;

        cur_ctr = '{default: '0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults after reset: rows are zero, so all partials vanish
        send_point(PT_MAX, PT_MIN, 40'sd12345, 1'b0);
        send_point(PT_MIN, PT_MAX, -40'sd1, 1'b1);
        settle();

        // Unit rotation, roll of half a radian
        load_setting(40'sd1000, -40'sd2000, 40'sd300000,
                     {16'h0000, 16'h0000, 16'h4000}, {16'h0000, 16'h4000, 16'h0000},
                     {16'h4000, 16'h0000, 16'h0000}, {16'd14378, 16'd7855}, 1'b0);
        send_point('0, '0, '0, 1'b0);
        send_point(PT_MAX, PT_MAX, PT_MAX, 1'b1);
        send_point(PT_MIN, PT_MIN, PT_MIN, 1'b0);
        send_point(40'sd1, -40'sd1, 40'sd1, 1'b1);
        send_point(40'sd1000, -40'sd2000, 40'sd300000, 1'b0);
        settle();

        // Most negative entries and centres: results from 41-bit differences saturate
        load_setting(PT_MIN, PT_MIN, PT_MIN, {3{16'h8000}}, {3{16'h8000}},
                     {3{16'h8000}}, 32'h8000_8000, 1'b0);
        send_point(PT_MAX, PT_MAX, PT_MAX, 1'b1);
        send_point(PT_MIN, PT_MIN, PT_MIN, 1'b0);
        send_point('0, PT_MAX, PT_MIN, 1'b1);
        settle();

        // Most positive entries and centres, with a write to an unmapped index
        load_setting(PT_MAX, PT_MAX, PT_MAX, {3{16'h7FFF}}, {3{16'h7FFF}},
                     {3{16'h7FFF}}, 32'h7FFF_7FFF, 1'b1);
        send_point(PT_MIN, PT_MIN, PT_MIN, 1'b0);
        send_point(PT_MAX, PT_MAX, PT_MAX, 1'b1);
        send_point(PT_MAX, PT_MIN, '0, 1'b0);
        settle();

        // Exact halves at both rounding steps, positive and negative
        load_setting('0, '0, '0, {16'h0000, 16'hFFFF, 16'h0001}, {3{16'h2000}},
                     '0, ROLL_TRIG_RST, 1'b0);
        send_point(40'sd8192, '0, '0, 1'b1);
        send_point(-40'sd8192, '0, '0, 1'b0);
        send_point(40'sd8192, -40'sd8192, 40'sd8191, 1'b1);
        settle();

        // Random phases: full-range, corner and survey-like settings in turn
        for (int ph = 0; ph < PHASES; ph++)
        begin
            pick    = $urandom_range(0, 2);
            gap_pct = (ph == PHASES - 1) ? 0 : (pick == 0 ? 0 : (pick == 1 ? 10 : 35));
            for (int i = 0; i < 3; i++)
            begin
                r64[i]  = {$urandom, $urandom};
                near[i] = $urandom;
                ext[i]  = ($urandom_range(0, 2) == 0) ? PT_MIN :
                          ($urandom_range(0, 1) == 0) ? PT_MAX : '0;
            end
            case (ph % 3)
                0:
                begin
                    load_setting(r64[0][PT_W-1:0], r64[1][PT_W-1:0], r64[2][PT_W-1:0],
                                 r64[0][63:16], r64[1][63:16], r64[2][63:16], $urandom,
                                 $urandom_range(0, 2) == 0);
                end
                1:
                begin
                    for (int i = 0; i < 3; i++)
                        for (int j = 0; j < 3; j++)
                            rw[i][ENT_W*j +: ENT_W] = $urandom_range(0, 1) ? 16'h8000
                                                                          : 16'h7FFF;
                    load_setting(ext[0], ext[1], ext[2], rw[0], rw[1], rw[2],
                                 {rand_entry(), rand_entry()}, $urandom_range(0, 2) == 0);
                end
                default:
                begin
                    for (int i = 0; i < 3; i++)
                        rw[i] = {rand_entry(), rand_entry(), rand_entry()};
                    load_setting(near[0], near[1], near[2], rw[0], rw[1], rw[2],
                                 {rand_entry(), rand_entry()}, $urandom_range(0, 2) == 0);
                end
            endcase

            for (int n = 0; n < PHASE_PTS; n++)
            begin
                if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge clk);
                end
                send_point(rand_coord(cur_ctr[0]), rand_coord(cur_ctr[1]),
                           rand_coord(cur_ctr[2]), 1'($urandom));
            end
            settle();
        end

        // Let any stray strobe show up before the verdict
        repeat (LATENCY + 4) @(posedge clk);

        $display("Streamed %0d points under %0d register settings; %0d result sets compared.",
                 pts_sent, settings, checked);
        $display("Covered reset defaults, saturation corners, half-LSB rounding, "
                 , "unmapped writes and back-to-back points.");
        if (pending != 0)
            $display("%0d result sets never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
